### design/assert_macros.svh
// Assertion macros used by the checker file of the I2C transfer sequencer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define I2CMTS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("I2C sequencer check failed");

// Same check, using the checker's standard clock and reset names.
`define I2CMTS_ASSERT_STD(name, prop) \
  `I2CMTS_ASSERT(name, clk_i, rst_ni, prop)

`endif

### design/i2cmts_pkg.sv
// Package of the I2C transfer sequencer: sizes, action and status codes,
// bus commands and the structs passed between modules. Depends on nothing.
package i2cmts_pkg;

  localparam int BufDepth = 16;
  localparam int BufIdxW  = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam int CntW     = 5;
  localparam int DataW    = 8;
  // Wide enough for any pointer or index plus a bit to test the depth.
  localparam int BufAddrW = ((BufIdxW > CntW) ? BufIdxW : CntW) + 1;

  localparam logic [1:0] ActLoad   = 2'd0;
  localparam logic [1:0] ActStart  = 2'd1;
  localparam logic [1:0] ActStatus = 2'd2;
  localparam logic [1:0] ActRead   = 2'd3;

  localparam logic [7:0] StatusMask   = 8'hfc;
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRepStart   = 8'h10;
  localparam logic [7:0] StAddrWrAck  = 8'h18;
  localparam logic [7:0] StDataWrAck  = 8'h28;
  localparam logic [7:0] StArbLost    = 8'h38;
  localparam logic [7:0] StAddrRdAck  = 8'h40;
  localparam logic [7:0] StDataRxAck  = 8'h50;
  localparam logic [7:0] StDataRxNack = 8'h58;

  localparam logic [DataW-1:0] RwFlag = 8'h01;

  typedef enum logic [2:0] {
    CmdNone  = 3'd0,
    CmdStart = 3'd1,
    CmdSend  = 3'd2,
    CmdRack  = 3'd3,
    CmdRnack = 3'd4,
    CmdStop  = 3'd5,
    CmdReset = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [3:0]       index;
    logic [DataW-1:0] data_in;
    logic [DataW-1:0] slave_address;
    logic [CntW-1:0]  write_count;
    logic [CntW-1:0]  read_count;
    logic [7:0]       bus_status;
  } item_t;

  typedef struct packed {
    cmd_e             bus_command;
    logic [DataW-1:0] tx_byte;
    logic [DataW-1:0] read_data;
    logic             write_done;
    logic             read_done;
  } rsp_t;

  // Write and clear requests from the sequencer to the buffer.
  typedef struct packed {
    logic                wr_en;
    logic [BufAddrW-1:0] wr_addr;
    logic [DataW-1:0]    wr_data;
    logic                clr_en;
    logic [CntW-1:0]     clr_cnt;
  } buf_req_t;

endpackage

### design/i2cmts_intf.sv
// Valid/ready channel interfaces of the I2C transfer sequencer: the request
// channel and the result channel. Depends on i2cmts_pkg.
interface i2cmts_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [3:0]                   index;
  logic [i2cmts_pkg::DataW-1:0] data_in;
  logic [i2cmts_pkg::DataW-1:0] slave_address;
  logic [i2cmts_pkg::CntW-1:0]  write_count;
  logic [i2cmts_pkg::CntW-1:0]  read_count;
  logic [7:0]                   bus_status;

  modport source (
    output valid, action, index, data_in, slave_address, write_count,
           read_count, bus_status,
    input  ready
  );
  modport sink (
    input  valid, action, index, data_in, slave_address, write_count,
           read_count, bus_status,
    output ready
  );
endinterface

interface i2cmts_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   bus_command;
  logic [i2cmts_pkg::DataW-1:0] tx_byte;
  logic [i2cmts_pkg::DataW-1:0] read_data;
  logic                         write_done;
  logic                         read_done;

  modport source (
    output valid, bus_command, tx_byte, read_data, write_done, read_done,
    input  ready
  );
  modport sink (
    input  valid, bus_command, tx_byte, read_data, write_done, read_done,
    output ready
  );
endinterface

### design/i2cmts_buf.sv
// Byte buffer of the I2C transfer sequencer with a per-entry filled mask.
// Depends on i2cmts_pkg.
module i2cmts_buf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  i2cmts_pkg::buf_req_t                req_i,
  input  logic [i2cmts_pkg::BufAddrW-1:0]     rd_addr_i,
  output logic [i2cmts_pkg::DataW-1:0]        rd_data_o
);

  localparam int AW = i2cmts_pkg::BufAddrW;
  localparam int IW = i2cmts_pkg::BufIdxW;

  logic [i2cmts_pkg::DataW-1:0]    mem_q [i2cmts_pkg::BufDepth];
  logic [i2cmts_pkg::BufDepth-1:0] fill_q, fill_d;
  logic                            wr_hit, rd_hit;
  logic [IW-1:0]                   wr_idx, rd_idx;

  assign wr_hit = req_i.wr_en && (req_i.wr_addr < AW'(i2cmts_pkg::BufDepth));
  assign rd_hit = rd_addr_i < AW'(i2cmts_pkg::BufDepth);
  assign wr_idx = req_i.wr_addr[IW-1:0];
  assign rd_idx = rd_addr_i[IW-1:0];

  // Entries below the read count lose their filled bit when a read phase opens.
  always_comb begin
    fill_d = fill_q;
    if (req_i.clr_en) begin
      for (int i = 0; i < i2cmts_pkg::BufDepth; i++) begin
        if (AW'(i) < AW'(req_i.clr_cnt)) begin
          fill_d[i] = 1'b0;
        end
      end
    end
    if (wr_hit) begin
      fill_d[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_idx] <= req_i.wr_data;
    end
  end

  assign rd_data_o = (rd_hit && fill_q[rd_idx]) ? mem_q[rd_idx] : '0;

endmodule

### design/i2cmts_seq.sv
// Transfer state and per-item decision logic of the I2C transfer sequencer.
// Depends on i2cmts_pkg; drives the buffer module's write and read ports.
module i2cmts_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  i2cmts_pkg::item_t               item_i,
  input  logic [i2cmts_pkg::DataW-1:0]    rd_data_i,
  output logic [i2cmts_pkg::BufAddrW-1:0] rd_addr_o,
  output i2cmts_pkg::buf_req_t            buf_req_o,
  output i2cmts_pkg::rsp_t                rsp_o
);

  localparam int AW = i2cmts_pkg::BufAddrW;
  localparam int CW = i2cmts_pkg::CntW;
  localparam logic [CW-1:0] PtrMax = '1;

  logic [i2cmts_pkg::DataW-1:0] addr_q, addr_d;
  logic [CW-1:0]                phase_q, phase_d;
  logic [CW-1:0]                pend_q, pend_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic                         wdone_q, wdone_d;
  logic                         rdone_q, rdone_d;
  logic [CW-1:0]                ptr_rx;
  logic [7:0]                   status;
  i2cmts_pkg::buf_req_t         req;
  i2cmts_pkg::cmd_e             cmd;
  logic [i2cmts_pkg::DataW-1:0] tx, rd;

  assign status    = item_i.bus_status & i2cmts_pkg::StatusMask;
  assign rd_addr_o = (item_i.action == i2cmts_pkg::ActRead) ? AW'(item_i.index) : AW'(ptr_q);

  always_comb begin
    addr_d  = addr_q;
    phase_d = phase_q;
    pend_d  = pend_q;
    ptr_d   = ptr_q;
    wdone_d = wdone_q;
    rdone_d = rdone_q;
    cmd     = i2cmts_pkg::CmdNone;
    tx      = '0;
    rd      = '0;
    ptr_rx  = ptr_q;
    req     = '0;
    req.wr_addr = AW'(ptr_q);
    req.wr_data = item_i.data_in;
    req.clr_cnt = pend_q;
    unique case (item_i.action)
      i2cmts_pkg::ActLoad: begin
        req.wr_en   = 1'b1;
        req.wr_addr = AW'(item_i.index);
      end
      i2cmts_pkg::ActStart: begin
        wdone_d = 1'b0;
        rdone_d = 1'b0;
        addr_d  = item_i.slave_address;
        pend_d  = item_i.read_count;
        if (item_i.write_count != '0) begin
          addr_d  = item_i.slave_address & ~i2cmts_pkg::RwFlag;
          phase_d = item_i.write_count;
          ptr_d   = '0;
          cmd     = i2cmts_pkg::CmdStart;
        end else if (item_i.read_count != '0) begin
          req.clr_en  = 1'b1;
          req.clr_cnt = item_i.read_count;
          addr_d  = item_i.slave_address | i2cmts_pkg::RwFlag;
          phase_d = item_i.read_count;
          ptr_d   = '0;
          cmd     = i2cmts_pkg::CmdStart;
        end
      end
      i2cmts_pkg::ActRead: begin
        rd = rd_data_i;
      end
      i2cmts_pkg::ActStatus: begin
        unique case (status)
          i2cmts_pkg::StStart, i2cmts_pkg::StRepStart: begin
            tx    = addr_q;
            ptr_d = '0;
            cmd   = i2cmts_pkg::CmdSend;
          end
          i2cmts_pkg::StAddrWrAck, i2cmts_pkg::StDataWrAck: begin
            if (ptr_q < phase_q) begin
              tx    = rd_data_i;
              ptr_d = ptr_q + CW'(1);
              cmd   = i2cmts_pkg::CmdSend;
            end else begin
              if (pend_q == '0) begin
                cmd = i2cmts_pkg::CmdStop;
              end else begin
                // Turn round into the read phase with a repeated start.
                req.clr_en = 1'b1;
                rdone_d    = 1'b0;
                addr_d     = addr_q | i2cmts_pkg::RwFlag;
                phase_d    = pend_q;
                ptr_d      = '0;
                cmd        = i2cmts_pkg::CmdStart;
              end
              wdone_d = 1'b1;
            end
          end
          i2cmts_pkg::StDataRxAck, i2cmts_pkg::StAddrRdAck: begin
            if (status == i2cmts_pkg::StDataRxAck) begin
              req.wr_en = 1'b1;
              if (ptr_q != PtrMax) begin
                ptr_rx = ptr_q + CW'(1);
              end
            end
            ptr_d = ptr_rx;
            // The byte that will be the last one gets a nack.
            if (({1'b0, ptr_rx} + (CW+1)'(1)) < {1'b0, phase_q}) begin
              cmd = i2cmts_pkg::CmdRack;
            end else begin
              cmd = i2cmts_pkg::CmdRnack;
            end
          end
          i2cmts_pkg::StDataRxNack: begin
            req.wr_en = 1'b1;
            rdone_d   = 1'b1;
            cmd       = i2cmts_pkg::CmdStop;
          end
          i2cmts_pkg::StArbLost: begin
            cmd = i2cmts_pkg::CmdStart;
          end
          default: begin
            wdone_d = 1'b1;
            rdone_d = 1'b1;
            cmd     = i2cmts_pkg::CmdReset;
          end
        endcase
      end
      default: begin
        cmd = i2cmts_pkg::CmdNone;
      end
    endcase
  end

  always_comb begin
    buf_req_o        = req;
    buf_req_o.wr_en  = req.wr_en && fire_i;
    buf_req_o.clr_en = req.clr_en && fire_i;
  end

  assign rsp_o.bus_command = cmd;
  assign rsp_o.tx_byte     = tx;
  assign rsp_o.read_data   = rd;
  assign rsp_o.write_done  = wdone_d;
  assign rsp_o.read_done   = rdone_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      phase_q <= '0;
      pend_q  <= '0;
      ptr_q   <= '0;
      wdone_q <= 1'b0;
      rdone_q <= 1'b0;
    end else if (fire_i) begin
      addr_q  <= addr_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      ptr_q   <= ptr_d;
      wdone_q <= wdone_d;
      rdone_q <= rdone_d;
    end
  end

endmodule

### design/i2c_master_transfer_sequencer_core.sv
// I2C master write-then-read transfer sequencer. Each request item is one of
// four actions: load a byte into the 16-entry buffer, start a transfer (slave
// address, write count, read count), present a bus status event, or read back
// a buffer byte. Every item yields exactly one result item carrying the bus
// command to issue, the byte to transmit, the buffer byte read back and the
// write and read done flags. The block takes one item per clock cycle while
// the result side takes its results; an item is decided in the cycle after it
// is accepted unless the result side stalls, and its result is registered and
// held on the result channel until it is taken. The throughput is set by the
// single decision stage,
// which reads the transfer state and one buffer entry and updates both in the
// same cycle. The request side keeps accepting while a finished result waits
// to be taken, as long as the input register is free to move on. No clearing
// pass follows reset: the filled mask clears at once, and buffer entries that
// were never written read back as zero.
// Depends on i2cmts_pkg, i2cmts_intf, i2cmts_buf and i2cmts_seq.
module i2c_master_transfer_sequencer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cmts_req_if.sink          req_i,
  i2cmts_rsp_if.source        rsp_o
);

  i2cmts_pkg::item_t                item_q;
  logic                             item_vld_q, item_vld_d;
  i2cmts_pkg::rsp_t                 rsp_q, rsp_d;
  logic                             rsp_vld_q, rsp_vld_d;
  logic                             fire;
  logic                             in_take;
  i2cmts_pkg::buf_req_t             buf_req;
  logic [i2cmts_pkg::BufAddrW-1:0]  rd_addr;
  logic [i2cmts_pkg::DataW-1:0]     rd_data;

  // The held item is decided when the result register is empty or is being
  // emptied in this cycle.
  assign fire    = item_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !item_vld_q || fire;
  assign in_take = req_i.valid && req_i.ready;

  assign item_vld_d = in_take ? 1'b1 : (fire ? 1'b0 : item_vld_q);
  assign rsp_vld_d  = fire ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action        <= req_i.action;
      item_q.index         <= req_i.index;
      item_q.data_in       <= req_i.data_in;
      item_q.slave_address <= req_i.slave_address;
      item_q.write_count   <= req_i.write_count;
      item_q.read_count    <= req_i.read_count;
      item_q.bus_status    <= req_i.bus_status;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Transfer state and command decision.
  i2cmts_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_q),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .buf_req_o (buf_req),
    .rsp_o     (rsp_d)
  );

  // Data buffer; one read address and one write per cycle.
  i2cmts_buf u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (buf_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.bus_command = rsp_q.bus_command;
  assign rsp_o.tx_byte     = rsp_q.tx_byte;
  assign rsp_o.read_data   = rsp_q.read_data;
  assign rsp_o.write_done  = rsp_q.write_done;
  assign rsp_o.read_done   = rsp_q.read_done;

endmodule

### design/i2cmts_checker.sv
// Port-level checker of the I2C transfer sequencer and its bind statement.
// Depends on i2cmts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cmts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] bus_command_i,
  input logic [7:0] tx_byte_i,
  input logic [7:0] read_data_i,
  input logic       write_done_i,
  input logic       read_done_i
);

  logic is_send, is_none, is_reset;

  assign is_send  = bus_command_i == i2cmts_pkg::CmdSend;
  assign is_none  = bus_command_i == i2cmts_pkg::CmdNone;
  assign is_reset = bus_command_i == i2cmts_pkg::CmdReset;

  // A stalled result keeps its command.
  `I2CMTS_ASSERT_STD(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(bus_command_i))
  // A transmit byte is only shown with a send command.
  `I2CMTS_ASSERT_STD(a_tx_only_send, rsp_valid_i && (tx_byte_i != 8'h00) |-> is_send)
  // Read-back data only comes with results that issue no bus command.
  `I2CMTS_ASSERT_STD(a_rd_no_cmd, rsp_valid_i && (read_data_i != 8'h00) |-> is_none)
  // An error reset raises both done flags.
  `I2CMTS_ASSERT_STD(a_reset_done, rsp_valid_i && is_reset |-> write_done_i && read_done_i)

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_i2cmts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .bus_command_i (rsp_o.bus_command),
  .tx_byte_i     (rsp_o.tx_byte),
  .read_data_i   (rsp_o.read_data),
  .write_done_i  (rsp_o.write_done),
  .read_done_i   (rsp_o.read_done)
);
